FILE: rtl/aemc_pkg.sv
// ----------------------------------------------------------------------------
// aemc_pkg
// shared types, register indexes, operation codes and reset values for the
// ambient eco mode controller
// ----------------------------------------------------------------------------
package aemc_pkg;

    // widths of the fields and registers
    localparam int TEMP_W   = 12;
    localparam int ENTRY_W  = 17;
    localparam int EXIT_W   = 16;
    localparam int WIN_W    = 8;
    localparam int QUOTA_W  = 4;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW      = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET_REQ = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_DELAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_WINDOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_QUOTA  = 3'd5;

    // register reset values (23.0 and 28.0 degrees in tenths)
    localparam logic signed [TEMP_W-1:0] RST_BAND_LOW    = 12'sd230;
    localparam logic signed [TEMP_W-1:0] RST_BAND_HIGH   = 12'sd280;
    localparam logic [ENTRY_W-1:0]       RST_ENTRY_DELAY = 17'd108000;
    localparam logic [EXIT_W-1:0]        RST_EXIT_DELAY  = 16'd43200;
    localparam logic [WIN_W-1:0]         RST_DRAW_WINDOW = 8'd120;
    localparam logic [QUOTA_W-1:0]       RST_DRAW_QUOTA  = 4'd4;

    // configuration register set
    typedef struct packed {
        logic signed [TEMP_W-1:0] band_low;
        logic signed [TEMP_W-1:0] band_high;
        logic [ENTRY_W-1:0]       entry_delay;
        logic [EXIT_W-1:0]        exit_delay;
        logic [WIN_W-1:0]         draw_window;
        logic [QUOTA_W-1:0]       draw_quota;
    } t_cfg;

    // one input item
    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [TEMP_W-1:0] ambient_temp;
    } t_item;

    // one result item
    typedef struct packed {
        logic               eco_active;
        logic               window_running;
        logic [QUOTA_W-1:0] draws_left;
    } t_result;

endpackage

FILE: rtl/ambient_eco_mode_controller.sv
// ----------------------------------------------------------------------------
// ambient_eco_mode_controller
// power-saving mode controller driven by temperature ticks, draw events and
// entry timer reset requests, with a plain register write port
// ----------------------------------------------------------------------------
// result: queued as its item is accepted, presented after older results
// throughput: one item per cycle while the result queue has room
// a two-entry result queue lets input continue while one result waits
// reset: synchronous, active low; registers return to their defaults and
// all counters reload from them, the queue empties
module ambient_eco_mode_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration port
    input  logic                               i_cfg_wr_en,
    input  logic [aemc_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [aemc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [aemc_pkg::OP_W-1:0]          i_operation,
    input  logic signed [aemc_pkg::TEMP_W-1:0] i_ambient_temp,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_eco_active,
    output logic                               o_window_running,
    output logic [aemc_pkg::QUOTA_W-1:0]       o_draws_left
);

    aemc_pkg::t_cfg    r_cfg;
    aemc_pkg::t_item   item;
    aemc_pkg::t_result result;
    aemc_pkg::t_result out_data;
    logic              accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band_low    <= aemc_pkg::RST_BAND_LOW;
            r_cfg.band_high   <= aemc_pkg::RST_BAND_HIGH;
            r_cfg.entry_delay <= aemc_pkg::RST_ENTRY_DELAY;
            r_cfg.exit_delay  <= aemc_pkg::RST_EXIT_DELAY;
            r_cfg.draw_window <= aemc_pkg::RST_DRAW_WINDOW;
            r_cfg.draw_quota  <= aemc_pkg::RST_DRAW_QUOTA;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                aemc_pkg::CFG_BAND_LOW:    r_cfg.band_low    <= i_cfg_wdata[11:0];
                aemc_pkg::CFG_BAND_HIGH:   r_cfg.band_high   <= i_cfg_wdata[11:0];
                aemc_pkg::CFG_ENTRY_DELAY: r_cfg.entry_delay <= i_cfg_wdata[16:0];
                aemc_pkg::CFG_EXIT_DELAY:  r_cfg.exit_delay  <= i_cfg_wdata[15:0];
                aemc_pkg::CFG_DRAW_WINDOW: r_cfg.draw_window <= i_cfg_wdata[7:0];
                aemc_pkg::CFG_DRAW_QUOTA:  r_cfg.draw_quota  <= i_cfg_wdata[3:0];
                default: begin
                    // unmapped index, no effect
                end
            endcase
        end
    end

    // input transaction
    assign accept            = i_in_valid & o_in_ready;
    assign item.operation    = i_operation;
    assign item.ambient_temp = i_ambient_temp;

    // state update
    aemc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // result queue
    aemc_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (result),
        .o_ready     (o_in_ready),
        .o_valid     (o_out_valid),
        .i_pop_ready (i_out_ready),
        .o_data      (out_data)
    );

    assign o_eco_active     = out_data.eco_active;
    assign o_window_running = out_data.window_running;
    assign o_draws_left     = out_data.draws_left;

endmodule

FILE: rtl/aemc_core.sv
// ----------------------------------------------------------------------------
// aemc_core
// mode state, entry/exit/window counters and the per-item update logic
// ----------------------------------------------------------------------------
module aemc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  aemc_pkg::t_item i_item,
    input  aemc_pkg::t_cfg  i_cfg,
    output aemc_pkg::t_result o_result
);

    logic                            r_mode_on;
    logic [aemc_pkg::ENTRY_W-1:0]    r_entry_timer;
    logic                            r_exit_armed;
    logic [aemc_pkg::EXIT_W-1:0]     r_exit_timer;
    logic                            r_window_open;
    logic [aemc_pkg::WIN_W-1:0]      r_window_timer;
    logic [aemc_pkg::QUOTA_W-1:0]    r_draw_counter;

    logic                            n_mode_on;
    logic [aemc_pkg::ENTRY_W-1:0]    n_entry_timer;
    logic                            n_exit_armed;
    logic [aemc_pkg::EXIT_W-1:0]     n_exit_timer;
    logic                            n_window_open;
    logic [aemc_pkg::WIN_W-1:0]      n_window_timer;
    logic [aemc_pkg::QUOTA_W-1:0]    n_draw_counter;

    logic in_band;

    // inclusive band test, an inverted band matches nothing
    assign in_band = (i_item.ambient_temp >= i_cfg.band_low) &&
                     (i_item.ambient_temp <= i_cfg.band_high);

    // next state for one item, steps applied in order
    always_comb begin
        n_mode_on      = r_mode_on;
        n_entry_timer  = r_entry_timer;
        n_exit_armed   = r_exit_armed;
        n_exit_timer   = r_exit_timer;
        n_window_open  = r_window_open;
        n_window_timer = r_window_timer;
        n_draw_counter = r_draw_counter;
        case (i_item.operation)
            aemc_pkg::OP_TICK: begin
                if (!r_mode_on) begin
                    // idle: count towards entry while in band, else reload the entry timer
                    if (in_band) begin
                        if (r_entry_timer <= 17'd1) begin
                            n_entry_timer  = '0;
                            n_mode_on      = 1'b1;
                            n_window_open  = 1'b0;
                            n_exit_armed   = 1'b0;
                            n_window_timer = i_cfg.draw_window;
                            n_draw_counter = i_cfg.draw_quota;
                            n_exit_timer   = i_cfg.exit_delay;
                        end else begin
                            n_entry_timer = r_entry_timer - 17'd1;
                        end
                    end else begin
                        n_entry_timer = i_cfg.entry_delay;
                    end
                end else begin
                    // active: temperature leaves band
                    if (!in_band) begin
                        n_mode_on     = 1'b0;
                        n_window_open = 1'b0;
                        n_exit_armed  = 1'b0;
                        n_entry_timer = i_cfg.entry_delay;
                    end
                    // exit countdown after first draw
                    if (n_exit_armed) begin
                        if (r_exit_timer <= 16'd1) begin
                            n_exit_timer  = '0;
                            n_mode_on     = 1'b0;
                            n_window_open = 1'b0;
                            n_exit_armed  = 1'b0;
                            n_entry_timer = i_cfg.entry_delay;
                        end else begin
                            n_exit_timer = r_exit_timer - 16'd1;
                        end
                    end
                    // draw window expiry
                    if (n_window_open) begin
                        if (r_window_timer != '0) begin
                            n_window_timer = r_window_timer - 8'd1;
                        end else if (r_draw_counter != '0) begin
                            n_mode_on     = 1'b0;
                            n_window_open = 1'b0;
                            n_exit_armed  = 1'b0;
                            n_entry_timer = i_cfg.entry_delay;
                        end else begin
                            n_window_open  = 1'b0;
                            n_window_timer = i_cfg.draw_window;
                            n_draw_counter = i_cfg.draw_quota;
                        end
                    end
                end
            end
            aemc_pkg::OP_DRAW: begin
                if (r_mode_on) begin
                    n_exit_armed  = 1'b1;
                    n_window_open = 1'b1;
                    if (r_window_timer == '0) begin
                        n_window_timer = i_cfg.draw_window;
                    end
                    if (r_draw_counter != '0) begin
                        n_draw_counter = r_draw_counter - 4'd1;
                    end
                end
            end
            aemc_pkg::OP_RESET_REQ: begin
                if (!r_mode_on) begin
                    n_entry_timer = i_cfg.entry_delay;
                end
            end
            default: begin
                // unused code leaves everything as it is
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_on      <= 1'b0;
            r_entry_timer  <= aemc_pkg::RST_ENTRY_DELAY;
            r_exit_armed   <= 1'b0;
            r_exit_timer   <= aemc_pkg::RST_EXIT_DELAY;
            r_window_open  <= 1'b0;
            r_window_timer <= aemc_pkg::RST_DRAW_WINDOW;
            r_draw_counter <= aemc_pkg::RST_DRAW_QUOTA;
        end else if (i_accept) begin
            r_mode_on      <= n_mode_on;
            r_entry_timer  <= n_entry_timer;
            r_exit_armed   <= n_exit_armed;
            r_exit_timer   <= n_exit_timer;
            r_window_open  <= n_window_open;
            r_window_timer <= n_window_timer;
            r_draw_counter <= n_draw_counter;
        end
    end

    // result reflects the state after the item
    assign o_result.eco_active     = n_mode_on;
    assign o_result.window_running = n_mode_on & n_window_open;
    assign o_result.draws_left     = n_mode_on ? n_draw_counter : '0;

`ifndef SYNTHESIS
    // idle mode never holds an open window or an armed exit
    a_idle_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_mode_on |-> (!r_window_open && !r_exit_armed))
        else $error("idle mode with window or exit flag set");

    // a draw while active opens the window and arms the exit
    a_draw_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_mode_on && i_item.operation == aemc_pkg::OP_DRAW)
        |=> (r_mode_on && r_exit_armed && r_window_open))
        else $error("draw while active did not arm exit and window");

    // an idle result reports no window and no draws
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !o_result.eco_active)
        |-> (!o_result.window_running && o_result.draws_left == '0))
        else $error("idle result carries window or draw count");
`endif

endmodule

FILE: rtl/aemc_out_buf.sv
// ----------------------------------------------------------------------------
// aemc_out_buf
// two-entry result queue between the update logic and the output channel
// ----------------------------------------------------------------------------
module aemc_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  aemc_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_pop_ready,
    output aemc_pkg::t_result o_data
);

    aemc_pkg::t_result r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid & i_pop_ready;
    assign o_data  = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    // fill level never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result queue overfilled");

    // a lone push raises the fill level by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("push did not raise fill level");

    // pointers agree with the fill level
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers out of step with fill level");
`endif

endmodule
